### src/bellman_log_utility_argmax_defines.svh
// Assertion macros shared by the bellman_log_utility_argmax RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef BELLMAN_LOG_UTILITY_ARGMAX_DEFINES_SVH
`define BELLMAN_LOG_UTILITY_ARGMAX_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BLUA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence required in the cycle after the trigger.
`define BLUA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### src/blua_pkg.sv
// Shared constants, types and the log2 interpolation table for the
// Bellman argmax block. No dependencies.
package blua_pkg;

  localparam int MAX_CHOICES    = 64;
  localparam int LOG_TABLE_SIZE = 32;
  localparam int QDEPTH         = 16;

  localparam int VAL_W      = 32;
  localparam int CHOICE_W   = 6;
  localparam int DISC_W     = 16;
  localparam int CNT_W      = $clog2(MAX_CHOICES);
  localparam int LOG_IDX_W  = $clog2(LOG_TABLE_SIZE + 1);
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CREDIT_W   = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [31:0]             LN2_Q32        = 32'd2977044472;
  localparam logic [DISC_W-1:0]       DISCOUNT_RST   = 16'd58982;
  localparam logic signed [VAL_W-1:0] INFEASIBLE_RST = -32'sd6488064;
  localparam logic signed [VAL_W-1:0] VAL_MIN        = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX        = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISCOUNT   = 1'b0,
    REG_INFEASIBLE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cand;
    logic                    last;
  } cand_beat_t;

  typedef logic [16:0] log_tab_t [LOG_TABLE_SIZE+1];

  // log2(1 + k/N) in Q0.16 by repeated squaring of a Q2.30 value
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] x;
    logic [16:0] r;
    for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
      x = 64'd1073741824 + ((64'(k) << 30) / LOG_TABLE_SIZE);
      r = '0;
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'd2147483648) begin
          r[0] = 1'b1;
          x    = x >> 1;
        end
      end
      tab[k] = r;
    end
    tab[LOG_TABLE_SIZE] = 17'd65536;
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

### src/blua_front.sv
// Front end: config registers, input handshake and the candidate pipeline
// (log2 by leading one + table, ln scaling, discount term). Uses blua_pkg.
`include "bellman_log_utility_argmax_defines.svh"
module blua_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [blua_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blua_pkg::VAL_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [blua_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tlast,
  output logic                             q_push,
  output blua_pkg::cand_beat_t             q_wdata,
  input  logic                             q_pop
);
  import blua_pkg::*;

  logic [DISC_W-1:0]       discount;
  logic signed [VAL_W-1:0] infeasible_value;
  logic [CREDIT_W-1:0]     credit;
  logic [CREDIT_W-1:0]     credit_next;
  logic                    accept;

  // per-stage control: bit 0 is stage 1
  logic [6:0] vld;
  logic [6:0] lst;
  logic [6:0] fea;

  // stage 1
  logic [30:0]             c1;
  logic signed [VAL_W-1:0] v1;
  // stage 2
  logic [4:0]  p2;
  logic [30:0] f2;
  logic [47:0] vprod2;
  logic        vneg2;
  // stage 3
  logic [4:0]        p3;
  logic [16:0]       lo3;
  logic [16:0]       d3;
  logic [30:0]       r3;
  logic signed [32:0] disc3;
  // stage 4
  logic [4:0]        p4;
  logic [16:0]       lo4;
  logic [47:0]       dr4;
  logic signed [32:0] disc4;
  // stage 5
  logic signed [21:0] lg5;
  logic signed [32:0] disc5;
  // stage 6
  logic [52:0]        lnprod6;
  logic               lnneg6;
  logic signed [32:0] disc6;
  // stage 7
  logic signed [21:0] ln7;
  logic signed [32:0] disc7;

  // combinational
  logic [4:0]               p_lead;
  logic [31:0]              norm;
  logic [31:0]              vmag;
  logic [30+LOG_IDX_W:0]    t;
  logic [LOG_IDX_W-1:0]     idx;
  logic [LOG_IDX_W-1:0]     idx_hi;
  logic [16:0]              lo_c;
  logic [16:0]              hi_c;
  logic [48:0]              dround;
  logic [17:0]              frac;
  logic signed [5:0]        pm16;
  logic [21:0]              lgmag;
  logic [53:0]              lnround;
  logic signed [33:0]       sum;
  logic signed [VAL_W-1:0]  sat;

  assign s_tready    = (credit < CREDIT_W'(QDEPTH));
  assign accept      = s_tvalid && s_tready;
  assign credit_next = credit + CREDIT_W'(accept) - CREDIT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      discount         <= DISCOUNT_RST;
      infeasible_value <= INFEASIBLE_RST;
      credit           <= '0;
      vld              <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DISCOUNT:   discount         <= cfg_wdata[DISC_W-1:0];
          REG_INFEASIBLE: infeasible_value <= cfg_wdata;
          default: ;
        endcase
      end
      credit <= credit_next;
      vld    <= {vld[5:0], accept};
    end
  end

  // stage 2 logic: leading one and normalize, |v| * discount
  always_comb begin
    p_lead = '0;
    for (int i = 0; i < 31; i++) begin
      if (c1[i]) p_lead = 5'(i);
    end
    norm = {1'b0, c1} << (5'd31 - p_lead);
    vmag = v1[VAL_W-1] ? 32'(-33'(v1)) : 32'(v1);
  end

  // stage 3 logic: table lookup and discount rounding
  always_comb begin
    t      = (31+LOG_IDX_W)'(f2) * (31+LOG_IDX_W)'(LOG_TABLE_SIZE);
    idx    = t[30+LOG_IDX_W:31];
    idx_hi = idx + LOG_IDX_W'(1);
    lo_c   = LOG_TAB[idx];
    hi_c   = LOG_TAB[idx_hi];
    dround = 49'(vprod2) + 49'd32768;
  end

  // stage 5 logic: interpolate and place the exponent
  always_comb begin
    frac = 18'(lo4) + 18'(dr4[47:31]);
    pm16 = $signed({1'b0, p4}) - 6'sd16;
  end

  // stage 6/7/push logic
  always_comb begin
    lgmag   = lg5[21] ? 22'(-lg5) : 22'(lg5);
    lnround = 54'(lnprod6) + 54'd2147483648;
    sum     = 34'(ln7) + 34'(disc7);
    if (sum > 34'(VAL_MAX))      sat = VAL_MAX;
    else if (sum < 34'(VAL_MIN)) sat = VAL_MIN;
    else                         sat = VAL_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c1 <= s_tdata[30:0];
      v1 <= s_tdata[63:32];
    end
    lst <= {lst[5:0], s_tlast};
    fea <= {fea[5:0], (!s_tdata[31] && (s_tdata[30:0] != '0))};
    // stage 2
    p2     <= p_lead;
    f2     <= norm[30:0];
    vprod2 <= 48'(vmag) * 48'(discount);
    vneg2  <= v1[VAL_W-1];
    // stage 3
    p3    <= p2;
    lo3   <= lo_c;
    d3    <= (hi_c > lo_c) ? (hi_c - lo_c) : '0;
    r3    <= t[30:0];
    disc3 <= vneg2 ? -$signed({1'b0, dround[47:16]}) : $signed({1'b0, dround[47:16]});
    // stage 4
    p4    <= p3;
    lo4   <= lo3;
    dr4   <= 48'(d3) * 48'(r3);
    disc4 <= disc3;
    // stage 5
    lg5   <= $signed({pm16, 16'b0}) + $signed({4'b0, frac});
    disc5 <= disc4;
    // stage 6
    lnprod6 <= 53'(lgmag[20:0]) * 53'(LN2_Q32);
    lnneg6  <= lg5[21];
    disc6   <= disc5;
    // stage 7
    ln7   <= lnneg6 ? -$signed({1'b0, lnround[52:32]}) : $signed({1'b0, lnround[52:32]});
    disc7 <= disc6;
  end

  assign q_push       = vld[6];
  assign q_wdata.cand = fea[6] ? sat : infeasible_value;
  assign q_wdata.last = lst[6];

  `BLUA_ASSERT(a_credit_bound, credit <= CREDIT_W'(QDEPTH), "front credit count overran queue depth")
  `BLUA_ASSERT_NEXT(a_credit_track, accept && !q_pop, credit == $past(credit) + CREDIT_W'(1), "credit did not count an accepted beat")

endmodule

### src/blua_queue.sv
// Candidate queue between front and back end; register file with
// head/tail pointers. Uses blua_pkg.
`include "bellman_log_utility_argmax_defines.svh"
module blua_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  blua_pkg::cand_beat_t  wdata,
  input  logic                  pop,
  output logic                  rvalid,
  output blua_pkg::cand_beat_t  rdata
);
  import blua_pkg::*;

  cand_beat_t          entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [CREDIT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  assign rvalid = (count != '0);
  assign rdata  = entries[rd_ptr];

  `BLUA_ASSERT(a_no_overflow, !(push && !pop && count == CREDIT_W'(QDEPTH)), "push into full queue")

endmodule

### src/blua_back.sv
// Back end: running max / first argmax over the candidates of one state
// and the result output register. Uses blua_pkg.
`include "bellman_log_utility_argmax_defines.svh"
module blua_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  blua_pkg::cand_beat_t            q_data,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [blua_pkg::OUT_DATA_W-1:0] m_tdata
);
  import blua_pkg::*;

  logic signed [VAL_W-1:0] running_max;
  logic [CNT_W-1:0]        running_argmax;
  logic [CNT_W-1:0]        choice_count;
  logic signed [VAL_W-1:0] max_next;
  logic [CNT_W-1:0]        argmax_next;
  logic                    out_valid;
  logic signed [VAL_W-1:0] best_value;
  logic [CHOICE_W-1:0]     best_choice;
  logic                    emit;

  // a last beat needs the output register free; others never stall
  assign q_pop = q_valid && (!q_data.last || !out_valid || m_tready);
  assign emit  = q_pop && q_data.last;

  always_comb begin
    if (q_data.cand > running_max) begin
      max_next    = q_data.cand;
      argmax_next = choice_count;
    end else begin
      max_next    = running_max;
      argmax_next = running_argmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max    <= VAL_MIN;
      running_argmax <= '0;
      choice_count   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_data.last) begin
          running_max    <= VAL_MIN;
          running_argmax <= '0;
          choice_count   <= '0;
        end else begin
          running_max    <= max_next;
          running_argmax <= argmax_next;
          if (choice_count < CNT_W'(MAX_CHOICES - 1)) choice_count <= choice_count + CNT_W'(1);
        end
      end
      if (emit)          out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      best_value  <= max_next;
      best_choice <= CHOICE_W'(argmax_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({best_choice, best_value});

  `BLUA_ASSERT_NEXT(a_clear_after_last, emit, choice_count == '0 && running_max == VAL_MIN, "state not cleared after last beat")
  `BLUA_ASSERT(a_argmax_le_count, running_argmax <= choice_count, "argmax ahead of choice count")

endmodule

### src/bellman_log_utility_argmax.sv
// Top level of the Bellman max/argmax block; ties front end, candidate
// queue and back end together. Uses blua_pkg and the blua_* modules.
//
// One choice beat is taken per clock while s_tready is high. Each beat
// scores ln(consumption) + discount * continuation (or the infeasible value
// when consumption is not positive) in a 7-stage front pipeline, then a queue
// of 16 entries feeds the running max/argmax. A state's result is registered
// into the output register as its tlast beat leaves the queue. s_tready drops
// only when 16 beats are taken but not yet consumed by the max stage, which
// happens when a result sits unclaimed in the output register and the next
// tlast beat reaches it. Write config only while no beat is in flight.
`include "bellman_log_utility_argmax_defines.svh"
module bellman_log_utility_argmax (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [blua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blua_pkg::VAL_W-1:0]      cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] consumption, [63:32] continuation
  input  logic [blua_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] best_value, [37:32] best_choice, [39:38] zero
  output logic [blua_pkg::OUT_DATA_W-1:0] m_tdata
);
  import blua_pkg::*;

  logic       q_push;
  cand_beat_t q_wdata;
  logic       q_pop;
  logic       q_valid;
  cand_beat_t q_rdata;

  blua_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_pop     (q_pop)
  );

  blua_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  blua_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
